// ===== hdl/gicu_pkg.sv =====
// Shared types, widths and codes for the grid interest cell update block.
// Used by gicu_divider and grid_interest_cell_update_unit; depends on nothing.
package gicu_pkg;

  // Field widths
  localparam int COORD_BITS  = 24;
  localparam int CELL_BITS   = 23;  // cell size and radius
  localparam int FUNC_BITS   = 2;
  localparam int KIND_BITS   = 2;
  localparam int CHANGE_BITS = 2;

  // Largest rectangle edge in cells
  localparam int MAX_SPAN = 4;

  // Numerator (position +/- radius) and signed quotient widths
  localparam int NUM_W = ((COORD_BITS > CELL_BITS) ? COORD_BITS : CELL_BITS + 1) + 1;
  localparam int QW    = NUM_W + 1;

  // Rectangle edge counts and result counts
  localparam int SPAN_W = $clog2(MAX_SPAN + 1);
  localparam int CNT_W  = $clog2(2 * MAX_SPAN * MAX_SPAN + 1);

  // Stream payload widths, padded to whole bytes
  localparam int IN_RAW_W   = CELL_BITS + 4 * COORD_BITS;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 2 * COORD_BITS + 2 + CHANGE_BITS;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [CELL_BITS-1:0] CELL_SIZE_RESET = CELL_BITS'(256);

  // Request operations
  localparam logic [FUNC_BITS-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_MOVE   = 2'd2;

  // Result kinds
  localparam logic [KIND_BITS-1:0] K_INSERT = 2'd0;
  localparam logic [KIND_BITS-1:0] K_UPDATE = 2'd1;
  localparam logic [KIND_BITS-1:0] K_REMOVE = 2'd2;
  localparam logic [KIND_BITS-1:0] K_ERROR  = 2'd3;

  // Centre cell change codes
  localparam logic [CHANGE_BITS-1:0] CHG_NONE = 2'd0;
  localparam logic [CHANGE_BITS-1:0] CHG_DROP = 2'd1;
  localparam logic [CHANGE_BITS-1:0] CHG_TAKE = 2'd2;

  // Quotient slots: one set for the new position, one for the old
  localparam int SET_SIZE = 6;
  localparam int NQ       = 2 * SET_SIZE;
  localparam int QI_W     = $clog2(NQ);
  localparam int Q_BC     = 0;  // floor((x - r) / cs)
  localparam int Q_BR     = 1;  // floor((z - r) / cs)
  localparam int Q_EC     = 2;  // floor((x + r) / cs)
  localparam int Q_ER     = 3;  // floor((z + r) / cs)
  localparam int Q_CX     = 4;  // floor(x / cs)
  localparam int Q_CZ     = 5;  // floor(z / cs)
  localparam int OLD_BASE = SET_SIZE;

  typedef logic signed [QW-1:0] cell_idx_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] numer;
  } div_req_t;

  typedef struct packed {
    logic      done;
    cell_idx_t quo;
  } div_rsp_t;

endpackage

// ===== hdl/gicu_divider.sv =====
// Signed floor divider by the cell size, one quotient bit per cycle (restoring).
// Depends on gicu_pkg.
module gicu_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  gicu_pkg::div_req_t             req,
  input  logic [gicu_pkg::CELL_BITS-1:0] divisor,
  output gicu_pkg::div_rsp_t             rsp
);
  import gicu_pkg::*;

  localparam int MAG_W  = NUM_W;
  localparam int STEP_W = $clog2(MAG_W);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIX  = 2'd2;

  logic [1:0]           state;
  logic [STEP_W-1:0]    step;
  logic [MAG_W-1:0]     dq;
  logic [CELL_BITS-1:0] acc;
  logic                 neg;
  logic [CELL_BITS:0]   shifted;
  logic [CELL_BITS+1:0] diff;
  logic                 fits;
  logic [MAG_W-1:0]     mag;
  logic [QW-1:0]        qx;

  // Trial subtract and operand magnitude
  always_comb begin
    shifted = {acc, dq[MAG_W-1]};
    diff    = {1'b0, shifted} - {2'b00, divisor};
    fits    = !diff[CELL_BITS+1];
    mag     = req.numer[NUM_W-1] ? $unsigned(-req.numer) : $unsigned(req.numer);
    qx      = {1'b0, dq};
  end

  // Sequence: load, shift-subtract per bit, then fix the sign toward minus infinity
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == D_FIX);
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            dq    <= mag;
            acc   <= '0;
            neg   <= req.numer[NUM_W-1];
            step  <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          acc  <= fits ? diff[CELL_BITS-1:0] : shifted[CELL_BITS-1:0];
          dq   <= {dq[MAG_W-2:0], fits};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(MAG_W - 1)) begin
            state <= D_FIX;
          end
        end
        D_FIX: begin
          // floor of a negative ratio: -q when exact, else -q - 1 (= ~q)
          if (neg) begin
            rsp.quo <= (acc != '0) ? ~qx : ~qx + QW'(1);
          end else begin
            rsp.quo <= qx;
          end
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/grid_interest_cell_update_unit.sv =====
// Grid interest cell update: takes one insert, remove or move request at a time on the
// slave stream and lists the affected grid cells on the master stream, row-major, with
// tlast on the final result of the request (a rectangle wider than four cells yields a
// single error result instead). The cell size register is written over the cfg channel,
// which is always ready; write it only between requests. Each request goes through one
// shared restoring divider that yields one quotient bit per cycle: insert and remove need
// 6 floor divisions, a move needs 12. After that the block checks the spans and then
// scans one cell per cycle, up to 16 for insert or remove and up to 48 for a move, except
// while a result is held up by the master side. s_axis_tready is high only while no
// request is in progress. An operation code of 3 is accepted and gives no result.
// Depends on gicu_pkg and gicu_divider.
module grid_interest_cell_update_unit (
  input  logic                            clk,
  input  logic                            rst,
  // Cell size register write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gicu_pkg::CELL_BITS-1:0]  cfg_data,
  // Requests
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, low to high: radius[23], pos_x[24], pos_z[24], old_x[24], old_z[24], zero pad
  input  logic [gicu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: func
  input  logic [gicu_pkg::FUNC_BITS-1:0]  s_axis_tuser,
  // Results
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, low to high: cell_row[24], cell_column[24], master, prev_master,
  // master_change[2], zero pad
  output logic [gicu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: kind
  output logic [gicu_pkg::KIND_BITS-1:0]  m_axis_tuser,
  output logic                            m_axis_tlast
);
  import gicu_pkg::*;

  localparam int RAD_LSB = 0;
  localparam int PX_LSB  = RAD_LSB + CELL_BITS;
  localparam int PZ_LSB  = PX_LSB + COORD_BITS;
  localparam int OX_LSB  = PZ_LSB + COORD_BITS;
  localparam int OZ_LSB  = OX_LSB + COORD_BITS;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV_GO   = 3'd1;
  localparam logic [2:0] S_DIV_WAIT = 3'd2;
  localparam logic [2:0] S_CHECK    = 3'd3;
  localparam logic [2:0] S_PLAN     = 3'd4;
  localparam logic [2:0] S_SCAN     = 3'd5;

  localparam logic [1:0] PH_NEW    = 2'd0;
  localparam logic [1:0] PH_SHARED = 2'd1;
  localparam logic [1:0] PH_OLD    = 2'd2;

  logic [2:0]                    state;
  logic [1:0]                    phase;
  logic [CELL_BITS-1:0]          cell_size;

  // Latched request
  logic [FUNC_BITS-1:0]          func;
  logic [CELL_BITS-1:0]          radius;
  logic signed [COORD_BITS-1:0]  pos_x;
  logic signed [COORD_BITS-1:0]  pos_z;
  logic signed [COORD_BITS-1:0]  old_x;
  logic signed [COORD_BITS-1:0]  old_z;
  logic                          is_move;
  logic                          func_known;

  // Division sequencing
  logic [QI_W-1:0]               k;
  logic [QI_W-1:0]               last_k;
  logic [QI_W-1:0]               rel;
  logic                          k_old;
  logic signed [COORD_BITS-1:0]  base;
  logic signed [NUM_W-1:0]       base_ext;
  logic signed [NUM_W-1:0]       rad_ext;
  logic signed [NUM_W-1:0]       numer;
  logic [CELL_BITS-1:0]          divisor;
  div_req_t                      div_req;
  div_rsp_t                      div_rsp;
  cell_idx_t                     quot [NQ];

  // Rectangles and centre cells, inclusive ends
  cell_idx_t nw_bc, nw_br, nw_ec, nw_er, nw_cx, nw_cz;
  cell_idx_t od_bc, od_br, od_ec, od_er, od_cx, od_cz;

  // Span check and overlap
  cell_idx_t                     wnc, wnr, woc, wor_d;
  cell_idx_t                     lo_c, hi_c, lo_r, hi_r;
  cell_idx_t                     ovc_d, ovr_d;
  cell_idx_t                     span_lim;
  logic                          err_c;
  logic                          span_err;
  logic                          migrate;
  logic [SPAN_W-1:0]             wn_c, wn_r, wo_c, wo_r, ov_c, ov_r;
  logic                          ov_c_ok, ov_r_ok;
  logic [CNT_W-1:0]              wdn_c, wdn_r, wdo_c, wdo_r, ic, ir;
  logic [CNT_W-1:0]              area_n, area_o, area_i, total_c;
  logic [CNT_W-1:0]              total;
  logic [CNT_W-1:0]              nout;

  // Cell scan
  cell_idx_t                     row, col;
  cell_idx_t cu_bc, cu_ec, cu_er;
  cell_idx_t ot_bc, ot_br, ot_ec, ot_er;
  logic                          in_other;
  logic                          hit_new, hit_old;
  logic                          want;
  logic                          out_free;
  logic                          advance;
  logic                          col_end, row_end;
  logic [KIND_BITS-1:0]          kind_s;
  logic                          master_s, prev_master_s, last_s;
  logic [CHANGE_BITS-1:0]        change_s;

  // Output register
  logic [KIND_BITS-1:0]          m_kind;
  logic [COORD_BITS-1:0]         m_row, m_col;
  logic                          m_master, m_prev_master, m_last;
  logic [CHANGE_BITS-1:0]        m_change;
  logic                          out_load;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = OUT_DATA_W'({m_change, m_prev_master, m_master, m_col, m_row});
  assign m_axis_tuser  = m_kind;
  assign m_axis_tlast  = m_last;

  assign is_move    = (func == FUNC_MOVE);
  assign func_known = (s_axis_tuser == FUNC_INSERT) || (s_axis_tuser == FUNC_REMOVE) ||
                      (s_axis_tuser == FUNC_MOVE);
  assign last_k     = is_move ? QI_W'(NQ - 1) : QI_W'(SET_SIZE - 1);

  // Pick the numerator for slot k: coordinate, minus or plus radius
  always_comb begin
    k_old    = (k >= QI_W'(OLD_BASE));
    rel      = k_old ? k - QI_W'(OLD_BASE) : k;
    if (rel == QI_W'(Q_BR) || rel == QI_W'(Q_ER) || rel == QI_W'(Q_CZ)) begin
      base = k_old ? old_z : pos_z;
    end else begin
      base = k_old ? old_x : pos_x;
    end
    base_ext = NUM_W'(base);
    rad_ext  = NUM_W'(radius);
    if (rel == QI_W'(Q_BC) || rel == QI_W'(Q_BR)) begin
      numer = base_ext - rad_ext;
    end else if (rel == QI_W'(Q_EC) || rel == QI_W'(Q_ER)) begin
      numer = base_ext + rad_ext;
    end else begin
      numer = base_ext;
    end
  end

  assign divisor       = (cell_size == '0) ? CELL_BITS'(1) : cell_size;
  assign div_req.start = (state == S_DIV_GO);
  assign div_req.numer = numer;

  gicu_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .req     (div_req),
    .divisor (divisor),
    .rsp     (div_rsp)
  );

  assign nw_bc = quot[Q_BC];
  assign nw_br = quot[Q_BR];
  assign nw_ec = quot[Q_EC];
  assign nw_er = quot[Q_ER];
  assign nw_cx = quot[Q_CX];
  assign nw_cz = quot[Q_CZ];
  assign od_bc = quot[OLD_BASE + Q_BC];
  assign od_br = quot[OLD_BASE + Q_BR];
  assign od_ec = quot[OLD_BASE + Q_EC];
  assign od_er = quot[OLD_BASE + Q_ER];
  assign od_cx = quot[OLD_BASE + Q_CX];
  assign od_cz = quot[OLD_BASE + Q_CZ];

  // Span check and overlap bounds
  always_comb begin
    span_lim = cell_idx_t'(MAX_SPAN);
    wnc      = nw_ec - nw_bc;
    wnr      = nw_er - nw_br;
    woc      = od_ec - od_bc;
    wor_d    = od_er - od_br;
    err_c    = (wnc >= span_lim) || (wnr >= span_lim) ||
               (is_move && ((woc >= span_lim) || (wor_d >= span_lim)));
    lo_c     = (nw_bc > od_bc) ? nw_bc : od_bc;
    hi_c     = (nw_ec < od_ec) ? nw_ec : od_ec;
    lo_r     = (nw_br > od_br) ? nw_br : od_br;
    hi_r     = (nw_er < od_er) ? nw_er : od_er;
    ovc_d    = hi_c - lo_c;
    ovr_d    = hi_r - lo_r;
  end

  // Result count: new area, plus old area less the overlap for a move
  always_comb begin
    wdn_c   = CNT_W'(wn_c) + CNT_W'(1);
    wdn_r   = CNT_W'(wn_r) + CNT_W'(1);
    wdo_c   = CNT_W'(wo_c) + CNT_W'(1);
    wdo_r   = CNT_W'(wo_r) + CNT_W'(1);
    ic      = ov_c_ok ? CNT_W'(ov_c) + CNT_W'(1) : '0;
    ir      = ov_r_ok ? CNT_W'(ov_r) + CNT_W'(1) : '0;
    area_n  = CNT_W'(wdn_c * wdn_r);
    area_o  = CNT_W'(wdo_c * wdo_r);
    area_i  = CNT_W'(ic * ir);
    total_c = is_move ? area_n + area_o - area_i : area_n;
  end

  // Scan: current rectangle, the other one, and what to say about this cell
  always_comb begin
    if (phase == PH_NEW) begin
      cu_bc = nw_bc; cu_ec = nw_ec; cu_er = nw_er;
      ot_bc = od_bc; ot_br = od_br; ot_ec = od_ec; ot_er = od_er;
    end else begin
      cu_bc = od_bc; cu_ec = od_ec; cu_er = od_er;
      ot_bc = nw_bc; ot_br = nw_br; ot_ec = nw_ec; ot_er = nw_er;
    end
    in_other = (row >= ot_br) && (row <= ot_er) && (col >= ot_bc) && (col <= ot_ec);
    hit_new  = (row == nw_cz) && (col == nw_cx);
    hit_old  = (row == od_cz) && (col == od_cx);
    unique case (phase)
      PH_NEW: begin
        want   = !is_move || !in_other;
        kind_s = (func == FUNC_REMOVE) ? K_REMOVE : K_INSERT;
      end
      PH_SHARED: begin
        want   = in_other;
        kind_s = K_UPDATE;
      end
      default: begin
        want   = !in_other;
        kind_s = K_REMOVE;
      end
    endcase
    master_s      = (phase == PH_OLD) ? hit_old : hit_new;
    prev_master_s = (phase == PH_SHARED) && hit_old;
    if (phase == PH_SHARED && migrate) begin
      change_s = hit_old ? CHG_DROP : (hit_new ? CHG_TAKE : CHG_NONE);
    end else begin
      change_s = CHG_NONE;
    end
    last_s   = (CNT_W'(nout + CNT_W'(1)) == total);
    out_free = !m_axis_tvalid || m_axis_tready;
    advance  = !want || out_free;
    col_end  = (col == cu_ec);
    row_end  = (row == cu_er);
  end

  // Load the output register this cycle
  assign out_load = ((state == S_PLAN) && span_err && out_free) ||
                    ((state == S_SCAN) && advance && want);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      cell_size     <= CELL_SIZE_RESET;
    end else begin
      if (cfg_valid) begin
        cell_size <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            func   <= s_axis_tuser;
            radius <= s_axis_tdata[RAD_LSB +: CELL_BITS];
            pos_x  <= s_axis_tdata[PX_LSB +: COORD_BITS];
            pos_z  <= s_axis_tdata[PZ_LSB +: COORD_BITS];
            old_x  <= s_axis_tdata[OX_LSB +: COORD_BITS];
            old_z  <= s_axis_tdata[OZ_LSB +: COORD_BITS];
            k      <= '0;
            state  <= func_known ? S_DIV_GO : S_IDLE;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            quot[k] <= div_rsp.quo;
            if (k == last_k) begin
              state <= S_CHECK;
            end else begin
              k     <= k + QI_W'(1);
              state <= S_DIV_GO;
            end
          end
        end
        S_CHECK: begin
          span_err <= err_c;
          migrate  <= (nw_cx != od_cx) || (nw_cz != od_cz);
          wn_c     <= wnc[SPAN_W-1:0];
          wn_r     <= wnr[SPAN_W-1:0];
          wo_c     <= woc[SPAN_W-1:0];
          wo_r     <= wor_d[SPAN_W-1:0];
          ov_c     <= ovc_d[SPAN_W-1:0];
          ov_r     <= ovr_d[SPAN_W-1:0];
          ov_c_ok  <= (hi_c >= lo_c);
          ov_r_ok  <= (hi_r >= lo_r);
          state    <= S_PLAN;
        end
        S_PLAN: begin
          if (span_err) begin
            // single error result
            if (out_free) begin
              m_axis_tvalid <= 1'b1;
              m_kind        <= K_ERROR;
              m_row         <= '0;
              m_col         <= '0;
              m_master      <= 1'b0;
              m_prev_master <= 1'b0;
              m_change      <= CHG_NONE;
              m_last        <= 1'b1;
              state         <= S_IDLE;
            end
          end else begin
            total <= total_c;
            nout  <= '0;
            phase <= PH_NEW;
            row   <= nw_br;
            col   <= nw_bc;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (advance) begin
            // emit this cell if it belongs to the current group
            if (want) begin
              m_axis_tvalid <= 1'b1;
              m_kind        <= kind_s;
              m_row         <= row[COORD_BITS-1:0];
              m_col         <= col[COORD_BITS-1:0];
              m_master      <= master_s;
              m_prev_master <= prev_master_s;
              m_change      <= change_s;
              m_last        <= last_s;
              nout          <= nout + CNT_W'(1);
            end
            // step to the next cell, rectangle or group
            if (!col_end) begin
              col <= col + cell_idx_t'(1);
            end else if (!row_end) begin
              col <= cu_bc;
              row <= row + cell_idx_t'(1);
            end else if (phase == PH_NEW && is_move) begin
              phase <= PH_SHARED;
              row   <= od_br;
              col   <= od_bc;
            end else if (phase == PH_SHARED) begin
              phase <= PH_OLD;
              row   <= od_br;
              col   <= od_bc;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (nout <= total))
    else $error("more cell results than planned");

  a_count_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) ##1 (state == S_IDLE) |-> (nout == total))
    else $error("scan ended before all planned results were sent");

  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == K_ERROR)) |-> (m_axis_tlast && (m_change == CHG_NONE)))
    else $error("span error result not marked last");

  a_div_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV_WAIT))
    else $error("divider finished with no division pending");
`endif

endmodule
